### src/tamd_pkg.sv
// Shared types, constants and helpers for the terrain alpha map decoder.
// No dependencies; the front, queue, back and top level import this package.
package tamd_pkg;

  localparam int IDX_W       = 12;   // pixel_index width on the result channel
  localparam int QUEUE_DEPTH = 4;    // power of two, pointers wrap naturally
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_COMPRESSED = 2'd0;
  localparam logic [1:0] REG_WIDE_ALPHA = 2'd1;
  localparam logic [1:0] REG_FIX_EDGES  = 2'd2;

  typedef struct packed {
    logic compressed;
    logic wide;
    logic fix_edges;
  } cfg_t;

  // one decoded byte, as handed from the front to the back
  typedef struct packed {
    logic [7:0] byte_val;  // fill/raw value, or two nibbles in packed mode
    logic [6:0] len;       // pixels covered by the first result
    logic       is_packed; // value is a nibble times 17, subject to edge fixing
    logic       pair;      // packed byte that also yields the high nibble pixel
    logic       fix;       // edge fixing enabled
    logic       at_start;  // first result of the map, position restarts at 0
  } op_t;

  // 0..15 onto 0..255 (times 17)
  function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
    return {nib, nib};
  endfunction

endpackage

### src/tamd_ifs.sv
// Valid/ready stream interfaces for the byte input and the result output.
// No dependencies.
interface tamd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       map_start;

  modport source (output valid, data_byte, map_start, input ready);
  modport sink   (input valid, data_byte, map_start, output ready);
endinterface

interface tamd_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_index;
  logic [7:0]  alpha_value;
  logic [6:0]  run_length;
  logic        last;
  logic        map_complete;

  modport source (output valid, pixel_index, alpha_value, run_length, last, map_complete,
                  input ready);
  modport sink   (input valid, pixel_index, alpha_value, run_length, last, map_complete,
                  output ready);
endinterface

### src/tamd_front.sv
// Front end: accepts stream bytes, runs the run-length phase machine and the
// map position, and queues one op per byte that yields pixels. Uses tamd_pkg.
module tamd_front #(
  parameter int MAP_PIXELS = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  tamd_pkg::cfg_t cfg,
  tamd_byte_if.sink      in_ch,
  output logic           q_push,
  output tamd_pkg::op_t  q_op,
  input  logic           q_full
);
  import tamd_pkg::*;

  localparam int PW = $clog2(MAP_PIXELS + 1);
  localparam logic [PW-1:0] MAP_END = PW'(MAP_PIXELS);

  localparam logic [1:0] PH_CONTROL = 2'd0;
  localparam logic [1:0] PH_FILL    = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic [1:0]    phase, phase_next;
  logic [6:0]    run, run_next;
  logic [PW-1:0] pos, pos_next;

  logic          accept;
  logic          push;
  logic [1:0]    ph_eff;
  logic [6:0]    run_eff;
  logic [PW-1:0] pos_eff;
  logic [PW-1:0] left;
  logic [6:0]    fill_len;
  logic          pair;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept && push;

  always_comb begin
    ph_eff   = in_ch.map_start ? PH_CONTROL : phase;
    run_eff  = in_ch.map_start ? 7'd0 : run;
    pos_eff  = in_ch.map_start ? '0 : pos;
    left     = MAP_END - pos_eff;
    fill_len = (PW'(run_eff) > left) ? left[6:0] : run_eff;
    pair     = (pos_eff + PW'(1)) < MAP_END;

    phase_next = ph_eff;
    run_next   = run_eff;
    pos_next   = pos_eff;
    push       = 1'b0;

    q_op.byte_val  = in_ch.data_byte;
    q_op.len       = 7'd1;
    q_op.is_packed = 1'b0;
    q_op.pair      = 1'b0;
    q_op.fix       = cfg.fix_edges;
    q_op.at_start  = (pos_eff == '0);

    // a full map ignores bytes until the next map_start
    if (pos_eff < MAP_END) begin
      if (cfg.compressed) begin
        unique case (ph_eff)
          PH_FILL: begin
            q_op.len   = fill_len;
            push       = (fill_len != 7'd0);
            pos_next   = pos_eff + PW'(fill_len);
            run_next   = 7'd0;
            phase_next = PH_CONTROL;
          end
          PH_LITERAL: begin
            push     = 1'b1;
            pos_next = pos_eff + PW'(1);
            run_next = run_eff - 7'd1;
            if (run_next == 7'd0) begin
              phase_next = PH_CONTROL;
            end
          end
          default: begin
            // control byte; the unused phase code lands here too
            run_next = in_ch.data_byte[6:0];
            if (in_ch.data_byte[7]) begin
              phase_next = PH_FILL;
            end else if (in_ch.data_byte[6:0] != 7'd0) begin
              phase_next = PH_LITERAL;
            end else begin
              phase_next = PH_CONTROL;
            end
          end
        endcase
      end else if (cfg.wide) begin
        push     = 1'b1;
        pos_next = pos_eff + PW'(1);
      end else begin
        push           = 1'b1;
        q_op.is_packed = 1'b1;
        q_op.pair      = pair;
        pos_next       = pos_eff + (pair ? PW'(2) : PW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CONTROL;
      run   <= 7'd0;
      pos   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      run   <= run_next;
      pos   <= pos_next;
    end
  end

endmodule

### src/tamd_queue.sv
// Short op queue between the front and the back so each side stalls alone.
// Uses tamd_pkg for op_t and the depth.
module tamd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tamd_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output tamd_pkg::op_t head,
  output logic          head_valid
);
  import tamd_pkg::*;

  op_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;

  assign full       = (count == (QUEUE_PW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PW + 1)'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
`endif

endmodule

### src/tamd_back.sv
// Back end: splits ops into pixels, applies edge fixing from the line store,
// writes the line store (fill runs swept one column a cycle), drives results.
// Uses tamd_pkg and tamd_result_if.
module tamd_back #(
  parameter int MAP_PIXELS = 4096,
  parameter int ROW_PIXELS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tamd_pkg::op_t hd,
  input  logic          hd_valid,
  output logic          pop,
  tamd_result_if.source out_ch
);
  import tamd_pkg::*;

  localparam int PW = $clog2(MAP_PIXELS + 1);
  localparam int CW = $clog2(ROW_PIXELS);
  localparam int XW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] MAP_END  = PW'(MAP_PIXELS);
  localparam logic [PW-1:0] LAST_ROW = PW'(MAP_PIXELS - ROW_PIXELS);
  localparam logic [CW-1:0] COL_LAST = CW'(ROW_PIXELS - 1);

  // line store: value last written to each column
  logic [7:0]    line_mem [ROW_PIXELS];
  logic [7:0]    rd_data;

  // issue side
  logic          half;       // low nibble pixel of a pair already issued
  logic [PW-1:0] pos_ptr;    // next pixel position
  logic [CW-1:0] col_ptr;    // its column
  logic          restart;
  logic [PW-1:0] pos_i;
  logic [CW-1:0] col_i;
  logic [7:0]    data_i;
  logic          issue_go;

  // pixel stage
  logic          b_valid;
  logic          b_emitted;
  logic [PW-1:0] b_pos;
  logic [CW-1:0] b_col;
  logic [7:0]    b_data;
  logic [6:0]    b_len;
  logic          b_packed;
  logic          b_fix;
  logic          b_last;
  logic [6:0]    sweep_left;
  logic [7:0]    b_val;
  logic [7:0]    last_val;   // most recent pixel value, i.e. column before this one
  logic [XW-1:0] b_pos_ext;
  logic          emit_go;
  logic          sweeping;
  logic          b_can_take;

  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic          out_valid;

  // issue
  always_comb begin
    restart = hd.at_start && !half;
    pos_i   = restart ? '0 : pos_ptr;
    col_i   = restart ? '0 : col_ptr;
    if (hd.is_packed) begin
      data_i = {4'h0, (half ? hd.byte_val[7:4] : hd.byte_val[3:0])};
    end else begin
      data_i = hd.byte_val;
    end
  end

  assign emit_go    = b_valid && !b_emitted && (!out_valid || out_ch.ready);
  assign sweeping   = b_valid && b_emitted && (sweep_left != 7'd0);
  assign b_can_take = !b_valid || (emit_go && b_len == 7'd1);
  assign issue_go   = hd_valid && b_can_take;
  assign pop        = issue_go && !(hd.pair && !half);

  // pixel value with edge fixing
  always_comb begin
    priority if (b_packed && b_fix && b_pos >= LAST_ROW) begin
      b_val = rd_data;
    end else if (b_packed && b_fix && b_col == COL_LAST) begin
      b_val = last_val;
    end else if (b_packed) begin
      b_val = expand_nibble(b_data[3:0]);
    end else begin
      b_val = b_data;
    end
  end

  assign b_pos_ext = XW'(b_pos);

  // the first pixel is written on emit, remaining fill pixels by the sweep
  assign mem_we    = emit_go || sweeping;
  assign mem_waddr = emit_go ? b_col : col_ptr;
  assign mem_wdata = emit_go ? b_val : b_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (issue_go) begin
      rd_data <= line_mem[col_i];
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      b_pos    <= pos_i;
      b_col    <= col_i;
      b_data   <= data_i;
      b_len    <= hd.len;
      b_packed <= hd.is_packed;
      b_fix    <= hd.fix;
      b_last   <= !hd.pair || half;
    end
    if (emit_go) begin
      last_val            <= b_val;
      out_ch.pixel_index  <= b_pos_ext[IDX_W-1:0];
      out_ch.alpha_value  <= b_val;
      out_ch.run_length   <= b_len;
      out_ch.last         <= b_last;
      out_ch.map_complete <= (b_pos + PW'(b_len)) >= MAP_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half       <= 1'b0;
      pos_ptr    <= '0;
      col_ptr    <= '0;
      b_valid    <= 1'b0;
      b_emitted  <= 1'b0;
      sweep_left <= 7'd0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_go) begin
        b_emitted  <= 1'b1;
        sweep_left <= b_len - 7'd1;
      end
      if (sweeping) begin
        sweep_left <= sweep_left - 7'd1;
        col_ptr    <= (col_ptr == COL_LAST) ? '0 : col_ptr + CW'(1);
      end
      if ((emit_go && b_len == 7'd1) || (sweeping && sweep_left == 7'd1)) begin
        b_valid <= 1'b0;
      end
      if (issue_go) begin
        b_valid   <= 1'b1;
        b_emitted <= 1'b0;
        half      <= hd.pair && !half;
        pos_ptr   <= pos_i + PW'(hd.len);
        col_ptr   <= (col_i == COL_LAST) ? '0 : col_i + CW'(1);
      end
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTH
  a_sweep_blocks_issue: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !issue_go)
    else $error("pixel issued during a fill sweep");
  // a new map may restart on column 0 while the old map's column 0 is written
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (issue_go && emit_go && !restart) |-> (col_i != b_col))
    else $error("line store read and write hit the same column");
  a_emitted_sweeps: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_emitted) |-> (sweep_left != 7'd0))
    else $error("finished pixel left in the pixel stage");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_ptr <= MAP_END)
    else $error("pixel position ran past the map end");
`endif

endmodule

### src/terrain_alpha_map_decoder_top.sv
// Terrain alpha map decoder, top level: configuration registers, front, queue, back.
// A result passes through a queue slot, the pixel stage and the output register after its byte is accepted.
// Throughput: one byte per cycle in run-length and raw modes while the queue is not full and
// the output is ready; a packed byte gives two results on one output register, and a fill run
// longer than one pixel holds the back while its remaining pixels are swept into the line store.
// Reset (rst, synchronous) restores the configuration registers and decode state; the line store is not cleared.
module terrain_alpha_map_decoder_top #(
  parameter int MAP_PIXELS = 4096,
  parameter int ROW_PIXELS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic          cfg_data,
  tamd_byte_if.sink     in_ch,
  tamd_result_if.source out_ch
);
  import tamd_pkg::*;

  cfg_t cfg;
  logic q_push;
  op_t  q_op;
  logic q_full;
  logic q_pop;
  op_t  q_head;
  logic q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.compressed <= 1'b0;
      cfg.wide       <= 1'b0;
      cfg.fix_edges  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_COMPRESSED: cfg.compressed <= cfg_data;
        REG_WIDE_ALPHA: cfg.wide       <= cfg_data;
        REG_FIX_EDGES:  cfg.fix_edges  <= cfg_data;
        default: ;
      endcase
    end
  end

  tamd_front #(
    .MAP_PIXELS (MAP_PIXELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_op   (q_op),
    .q_full (q_full)
  );

  tamd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  tamd_back #(
    .MAP_PIXELS (MAP_PIXELS),
    .ROW_PIXELS (ROW_PIXELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .hd       (q_head),
    .hd_valid (q_valid),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

endmodule
